[hw/rtl/assert_macros.svh]
// assertion helpers for the player slot assigner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on the rising clock, switched off while reset is low
`define PSLOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on the rising clock, also live during reset
`define PSLOT_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/pslot_pkg.sv]
package pslot_pkg;

  // defaults of the top level parameters
  localparam int unsigned MAX_DEVICES_DEF = 8;
  localparam int unsigned MAX_PLAYERS_DEF = 4;
  localparam int unsigned ID_BITS_DEF     = 16;

  // fixed payload widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DEV_ID_W = 16;
  localparam int unsigned PLAYER_W = 5;
  localparam int unsigned HELD_W   = 16;

  typedef logic signed [PLAYER_W-1:0] player_t;

  localparam player_t NO_PLAYER = 5'sb11111;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONNECT    = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_INPUT      = 3'd2,
    CMD_REASSIGN   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_CLR,
    S_DONE
  } st_e;

  // what one pass over the table found
  typedef struct packed {
    logic              found;
    player_t           player;
    logic              ready;
    logic              free_found;
    logic [HELD_W-1:0] held;
  } scan_t;

  // held mask bit of a player number, none for no player
  function automatic logic [HELD_W-1:0] ply_bit(player_t p);
    logic [HELD_W-1:0] b;
    b = p[PLAYER_W-1] ? '0 : (HELD_W'(1) << p[PLAYER_W-2:0]);
    return b;
  endfunction

endpackage

[hw/rtl/pslot_if.sv]
// command channel
interface pslot_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [pslot_pkg::CMD_W-1:0]    command;
  logic [pslot_pkg::DEV_ID_W-1:0] device_id;
  logic                           built_in;
  logic                           neutral;
  logic                           button_pressed;

  modport source (output valid, command, device_id, built_in, neutral, button_pressed,
                  input ready);
  modport sink (input valid, command, device_id, built_in, neutral, button_pressed,
                output ready);
endinterface

// response channel
interface pslot_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  pslot_pkg::player_t           player_number;
  logic [pslot_pkg::HELD_W-1:0] held_mask;

  modport source (output valid, ok, player_number, held_mask, input ready);
  modport sink (input valid, ok, player_number, held_mask, output ready);
endinterface

[hw/rtl/player_slot_assigner.sv]
// channel   dir  payload                                        item accepted
// cmd_i     in   command, device_id, built_in, neutral, button  valid & ready
// rsp_o     out  ok, player_number, held_mask                   valid & ready
//
// one command at a time; a command reads every table entry through the one
// memory read port; reassign instead writes every entry once
// reset clears the entry valid bits, the reservation and the reassign flag
// a stalled output holds the next result in the done state, cmd_i.ready low
`include "assert_macros.svh"

module player_slot_assigner #(
  parameter int unsigned MAX_DEVICES = pslot_pkg::MAX_DEVICES_DEF,
  parameter int unsigned MAX_PLAYERS = pslot_pkg::MAX_PLAYERS_DEF,
  parameter int unsigned ID_BITS     = pslot_pkg::ID_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  pslot_cmd_if.sink   cmd_i,
  pslot_rsp_if.source rsp_o
);

  localparam int unsigned IdxW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_DEVICES + 1);
  localparam int unsigned HeldW = pslot_pkg::HELD_W;
  localparam logic [HeldW-1:0] PlyMask = HeldW'((64'd1 << MAX_PLAYERS) - 64'd1);

  pslot_pkg::st_e           state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [pslot_pkg::CMD_W-1:0] cmd_q;
  logic [ID_BITS-1:0]       key_q;
  logic                     built_q, neut_q, press_q;
  logic [MAX_DEVICES-1:0]   valid_q, valid_d;
  logic                     zres_q, zres_d;
  logic                     wasr_q, wasr_d;
  logic                     stg_ok_q, stg_ok_d;
  pslot_pkg::player_t       stg_ply_q, stg_ply_d;
  logic [HeldW-1:0]         stg_held_q, stg_held_d;
  logic                     stg_ld;
  logic                     out_vld_q, out_vld_d;
  logic                     out_ok_q;
  pslot_pkg::player_t       out_ply_q;
  logic [HeldW-1:0]         out_held_q;

  logic                     accept, out_ld, cmd_rdy, rd_en;
  logic [IdxW-1:0]          wr_addr;
  logic                     id_we, st_we, wr_rdy;
  pslot_pkg::player_t       wr_ply;

  logic                     rd_vld, rd_rdy;
  logic [IdxW-1:0]          rd_idx;
  logic [ID_BITS-1:0]       rd_id;
  pslot_pkg::player_t       rd_ply;
  pslot_pkg::scan_t         sr;
  logic [IdxW-1:0]          sr_slot, sr_free;

  logic                     scan_last, clr_last;
  logic                     conn_ok, reserve, in_open, in_rdy, in_assign;
  pslot_pkg::player_t       conn_ply, found_ply, low_ply;
  logic [HeldW-1:0]         free_vec, low_oh;
  logic [3:0]               low_num;

  assign accept    = cmd_i.valid && cmd_i.ready;
  assign out_ld    = (state_q == pslot_pkg::S_DONE) && (!out_vld_q || rsp_o.ready);
  assign scan_last = (cnt_q == CntW'(MAX_DEVICES));
  assign clr_last  = (cnt_q == CntW'(MAX_DEVICES - 1));

  // entry memory
  pslot_table #(
    .MAX_DEVICES(MAX_DEVICES),
    .ID_BITS    (ID_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (cnt_q[IdxW-1:0]),
    .wr_addr_i  (wr_addr),
    .id_we_i    (id_we),
    .st_we_i    (st_we),
    .wr_id_i    (key_q),
    .wr_player_i(wr_ply),
    .wr_ready_i (wr_rdy),
    .rd_vld_o   (rd_vld),
    .rd_idx_o   (rd_idx),
    .rd_id_o    (rd_id),
    .rd_player_o(rd_ply),
    .rd_ready_o (rd_rdy)
  );

  // match, free slot and held mask from the read stream
  pslot_scan #(
    .MAX_DEVICES(MAX_DEVICES),
    .ID_BITS    (ID_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .key_i      (key_q),
    .valid_i    (valid_q),
    .rd_vld_i   (rd_vld),
    .rd_idx_i   (rd_idx),
    .rd_id_i    (rd_id),
    .rd_player_i(rd_ply),
    .rd_ready_i (rd_rdy),
    .res_o      (sr),
    .slot_o     (sr_slot),
    .free_o     (sr_free)
  );

  // lowest player number neither held nor reserved
  assign free_vec = ~(sr.held | {{(HeldW-1){1'b0}}, zres_q}) & PlyMask;
  assign low_oh   = free_vec & (~free_vec + HeldW'(1));

  always_comb begin
    low_num = '0;
    for (int i = 0; i < HeldW; i++) begin
      if (low_oh[i]) begin
        low_num = low_num | 4'(i);
      end
    end
  end

  assign low_ply = pslot_pkg::player_t'({1'b0, low_num});

  // command decisions from the scan result
  assign found_ply = sr.found ? sr.player : pslot_pkg::NO_PLAYER;
  assign conn_ok   = (key_q != '0) && !sr.found && sr.free_found;
  assign reserve   = built_q && !wasr_q;
  assign conn_ply  = (reserve && !sr.held[0]) ? '0 : pslot_pkg::NO_PLAYER;
  assign in_open   = sr.found && sr.player[pslot_pkg::PLAYER_W-1];
  assign in_rdy    = sr.ready || neut_q;
  assign in_assign = in_rdy && press_q && (free_vec != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pslot_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (cmd_i.command == pslot_pkg::CMD_REASSIGN) ? pslot_pkg::S_CLR
                                                               : pslot_pkg::S_SCAN;
        end
      end
      pslot_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = pslot_pkg::S_ACT;
        end
      end
      pslot_pkg::S_ACT: begin
        state_d = pslot_pkg::S_DONE;
      end
      pslot_pkg::S_CLR: begin
        if (clr_last) begin
          state_d = pslot_pkg::S_DONE;
        end
      end
      pslot_pkg::S_DONE: begin
        if (out_ld) begin
          state_d = pslot_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pslot_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs: reads, write-back and staged result
  always_comb begin
    cmd_rdy    = 1'b0;
    rd_en      = 1'b0;
    cnt_d      = cnt_q;
    wr_addr    = cnt_q[IdxW-1:0];
    id_we      = 1'b0;
    st_we      = 1'b0;
    wr_ply     = pslot_pkg::NO_PLAYER;
    wr_rdy     = 1'b0;
    valid_d    = valid_q;
    zres_d     = zres_q;
    wasr_d     = wasr_q;
    stg_ld     = 1'b0;
    stg_ok_d   = 1'b0;
    stg_ply_d  = found_ply;
    stg_held_d = sr.held;
    case (state_q)
      pslot_pkg::S_IDLE: begin
        cmd_rdy = 1'b1;
        cnt_d   = '0;
      end
      pslot_pkg::S_SCAN: begin
        rd_en = !scan_last;
        cnt_d = cnt_q + CntW'(1);
      end
      pslot_pkg::S_ACT: begin
        stg_ld = 1'b1;
        case (cmd_q)
          pslot_pkg::CMD_CONNECT: begin
            stg_ok_d   = conn_ok;
            stg_ply_d  = conn_ok ? conn_ply : found_ply;
            stg_held_d = sr.held | (conn_ok ? pslot_pkg::ply_bit(conn_ply) : '0);
            if (conn_ok) begin
              wr_addr          = sr_free;
              id_we            = 1'b1;
              st_we            = 1'b1;
              wr_ply           = conn_ply;
              valid_d[sr_free] = 1'b1;
              if (reserve) begin
                zres_d = 1'b1;
              end
            end
          end
          pslot_pkg::CMD_DISCONNECT: begin
            stg_ok_d  = sr.found;
            stg_ply_d = pslot_pkg::NO_PLAYER;
            if (sr.found) begin
              stg_held_d       = sr.held & ~pslot_pkg::ply_bit(sr.player);
              valid_d[sr_slot] = 1'b0;
            end
          end
          pslot_pkg::CMD_INPUT: begin
            if (in_open) begin
              wr_addr    = sr_slot;
              st_we      = 1'b1;
              wr_ply     = in_assign ? low_ply : pslot_pkg::NO_PLAYER;
              wr_rdy     = in_assign ? 1'b0 : in_rdy;
              stg_ok_d   = in_assign;
              stg_ply_d  = in_assign ? low_ply : pslot_pkg::NO_PLAYER;
              stg_held_d = sr.held | (in_assign ? pslot_pkg::ply_bit(low_ply) : '0);
            end
          end
          pslot_pkg::CMD_QUERY: begin
            stg_ok_d = 1'b1;
          end
          default: begin
            stg_ok_d = 1'b0;
          end
        endcase
      end
      pslot_pkg::S_CLR: begin
        // drop every player number and ready flag, one entry a cycle
        st_we      = 1'b1;
        cnt_d      = cnt_q + CntW'(1);
        stg_ld     = 1'b1;
        stg_ok_d   = 1'b1;
        stg_ply_d  = pslot_pkg::NO_PLAYER;
        stg_held_d = '0;
        if (clr_last) begin
          zres_d = 1'b0;
          wasr_d = 1'b1;
        end
      end
      pslot_pkg::S_DONE: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  assign cmd_i.ready = cmd_rdy;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pslot_pkg::S_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      zres_q    <= 1'b0;
      wasr_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      zres_q    <= zres_d;
      wasr_q    <= wasr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // command capture, staged result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i.command;
      key_q   <= ID_BITS'(cmd_i.device_id);
      built_q <= cmd_i.built_in;
      neut_q  <= cmd_i.neutral;
      press_q <= cmd_i.button_pressed;
    end
    if (stg_ld) begin
      stg_ok_q   <= stg_ok_d;
      stg_ply_q  <= stg_ply_d;
      stg_held_q <= stg_held_d;
    end
    if (out_ld) begin
      out_ok_q   <= stg_ok_q;
      out_ply_q  <= stg_ply_q;
      out_held_q <= stg_held_q;
    end
  end

  // output register valid
  assign out_vld_d = out_ld || (out_vld_q && !rsp_o.ready);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.ok            = out_ok_q;
  assign rsp_o.player_number = out_ply_q;
  assign rsp_o.held_mask     = out_held_q;

  // checks
  `PSLOT_ASSERT_ALL(a_wr_phase, (id_we || st_we) |-> ((state_q == pslot_pkg::S_ACT) || (state_q == pslot_pkg::S_CLR)), "table written outside act or clear")
  `PSLOT_ASSERT(a_accept_busy, accept |=> (state_q != pslot_pkg::S_IDLE), "accepted item did not start work")
  `PSLOT_ASSERT(a_ply_range, out_vld_q |-> ((out_ply_q == pslot_pkg::NO_PLAYER) || (!out_ply_q[4] && ({28'd0, out_ply_q[3:0]} < MAX_PLAYERS))), "player number out of range")
  `PSLOT_ASSERT(a_held_range, out_vld_q |-> ((out_held_q >> MAX_PLAYERS) == '0), "held mask beyond player count")

endmodule

[hw/rtl/pslot_table.sv]
module pslot_table #(
  parameter int unsigned MAX_DEVICES = pslot_pkg::MAX_DEVICES_DEF,
  parameter int unsigned ID_BITS     = pslot_pkg::ID_BITS_DEF,
  localparam int unsigned IdxW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IdxW-1:0]    rd_addr_i,
  input  logic [IdxW-1:0]    wr_addr_i,
  input  logic               id_we_i,
  input  logic               st_we_i,
  input  logic [ID_BITS-1:0] wr_id_i,
  input  pslot_pkg::player_t wr_player_i,
  input  logic               wr_ready_i,
  output logic               rd_vld_o,
  output logic [IdxW-1:0]    rd_idx_o,
  output logic [ID_BITS-1:0] rd_id_o,
  output pslot_pkg::player_t rd_player_o,
  output logic               rd_ready_o
);

  // device ids, and player number plus ready flag per entry
  logic [ID_BITS-1:0]            id_mem [MAX_DEVICES];
  logic [pslot_pkg::PLAYER_W:0]  st_mem [MAX_DEVICES];
  logic [pslot_pkg::PLAYER_W:0]  st_rd;
  logic                          rd_vld_q;
  logic [IdxW-1:0]               rd_idx_q;

  // write ports
  always_ff @(posedge clk_i) begin
    if (id_we_i) begin
      id_mem[wr_addr_i] <= wr_id_i;
    end
    if (st_we_i) begin
      st_mem[wr_addr_i] <= {wr_player_i, wr_ready_i};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_id_o  <= id_mem[rd_addr_i];
      st_rd    <= st_mem[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_i;
    end
  end

  assign rd_vld_o    = rd_vld_q;
  assign rd_idx_o    = rd_idx_q;
  assign rd_player_o = pslot_pkg::player_t'(st_rd[pslot_pkg::PLAYER_W:1]);
  assign rd_ready_o  = st_rd[0];

endmodule

[hw/rtl/pslot_scan.sv]
module pslot_scan #(
  parameter int unsigned MAX_DEVICES = pslot_pkg::MAX_DEVICES_DEF,
  parameter int unsigned ID_BITS     = pslot_pkg::ID_BITS_DEF,
  localparam int unsigned IdxW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ID_BITS-1:0]     key_i,
  input  logic [MAX_DEVICES-1:0] valid_i,
  input  logic                   rd_vld_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  input  logic [ID_BITS-1:0]     rd_id_i,
  input  pslot_pkg::player_t     rd_player_i,
  input  logic                   rd_ready_i,
  output pslot_pkg::scan_t       res_o,
  output logic [IdxW-1:0]        slot_o,
  output logic [IdxW-1:0]        free_o
);

  pslot_pkg::scan_t res_q, res_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [IdxW-1:0]  free_q, free_d;

  // clear on start, else fold one table entry into the match, free slot and held mask
  always_comb begin
    res_d  = res_q;
    slot_d = slot_q;
    free_d = free_q;
    if (start_i) begin
      res_d.found      = 1'b0;
      res_d.player     = pslot_pkg::NO_PLAYER;
      res_d.ready      = 1'b0;
      res_d.free_found = 1'b0;
      res_d.held       = '0;
    end else if (rd_vld_i) begin
      if (valid_i[rd_idx_i]) begin
        res_d.held = res_q.held | pslot_pkg::ply_bit(rd_player_i);
        if (rd_id_i == key_i) begin
          res_d.found  = 1'b1;
          res_d.player = rd_player_i;
          res_d.ready  = rd_ready_i;
          slot_d       = rd_idx_i;
        end
      end else if (!res_q.free_found) begin
        res_d.free_found = 1'b1;
        free_d           = rd_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      slot_q <= '0;
      free_q <= '0;
    end else begin
      res_q  <= res_d;
      slot_q <= slot_d;
      free_q <= free_d;
    end
  end

  assign res_o  = res_q;
  assign slot_o = slot_q;
  assign free_o = free_q;

endmodule

[tb/player_slot_assigner_tb.sv]
`timescale 1ns / 1ps

module player_slot_assigner_tb;

  typedef logic [pslot_pkg::CMD_W-1:0]    cmd_t;
  typedef logic [pslot_pkg::DEV_ID_W-1:0] dev_id_t;

  localparam int unsigned NUM_DEV      = pslot_pkg::MAX_DEVICES_DEF;
  localparam int unsigned NUM_PLAYERS  = pslot_pkg::MAX_PLAYERS_DEF;
  localparam int unsigned LATENCY      = NUM_DEV + 4;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned BLOCK_ITEMS  = 100;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned LONG_HOLD    = 150;
  // highest command code, not defined by the block
  localparam cmd_t CMD_TOP = '1;

  typedef struct packed {
    logic                         ok;
    pslot_pkg::player_t           player;
    logic [pslot_pkg::HELD_W-1:0] held;
  } answer_t;

  typedef struct {
    bit                 used;
    dev_id_t            id;
    pslot_pkg::player_t player;
    bit                 armed;
  } device_t;

  logic clk;
  logic rst_n;

  pslot_cmd_if cmd_bus ();
  pslot_rsp_if rsp_bus ();

  player_slot_assigner #(
    .MAX_DEVICES(pslot_pkg::MAX_DEVICES_DEF),
    .MAX_PLAYERS(pslot_pkg::MAX_PLAYERS_DEF),
    .ID_BITS    (pslot_pkg::ID_BITS_DEF)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  // shadow of the device table
  device_t             devices[NUM_DEV];
  bit                  zero_reserved;
  bit                  reassigned;
  answer_t             owed_answers[$];
  int unsigned         mismatches;
  bit                  cmd_calm;
  bit                  rsp_calm;
  int unsigned         rsp_hold_req;
  dev_id_t             id_pool[POOL_SIZE];

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int find_device(dev_id_t id);
    for (int i = 0; i < NUM_DEV; i++) begin
      if (devices[i].used && devices[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [pslot_pkg::HELD_W-1:0] held_players();
    logic [pslot_pkg::HELD_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < NUM_DEV; i++) begin
      if (devices[i].used && !devices[i].player[pslot_pkg::PLAYER_W-1])
        mask[devices[i].player[pslot_pkg::PLAYER_W-2:0]] = 1'b1;
    end
    return mask;
  endfunction

  function automatic pslot_pkg::player_t lowest_free_player();
    logic [pslot_pkg::HELD_W-1:0] taken;
    taken    = held_players();
    taken[0] = taken[0] | zero_reserved;
    for (int p = 0; p < NUM_PLAYERS; p++) begin
      if (!taken[p]) return pslot_pkg::player_t'(p);
    end
    return pslot_pkg::NO_PLAYER;
  endfunction

  // apply one command to the shadow table and return the answer it gives
  function automatic answer_t apply_command(cmd_t cmd, dev_id_t id,
                                            bit built_in, bit neutral, bit pressed);
    answer_t                      ans;
    int                           slot;
    int                           spare;
    pslot_pkg::player_t           p;
    logic [pslot_pkg::HELD_W-1:0] held;
    ans.ok = 1'b0;
    case (cmd)
      pslot_pkg::CMD_CONNECT: begin
        spare = -1;
        for (int i = NUM_DEV - 1; i >= 0; i--) begin
          if (!devices[i].used) spare = i;
        end
        if (id != '0 && find_device(id) < 0 && spare >= 0) begin
          devices[spare].id     = id;
          devices[spare].player = pslot_pkg::NO_PLAYER;
          devices[spare].armed  = 1'b0;
          // built-in before any reassign: reserve player 0, take it if free
          if (built_in && !reassigned) begin
            zero_reserved = 1'b1;
            held = held_players();
            if (!held[0]) devices[spare].player = '0;
          end
          devices[spare].used = 1'b1;
          ans.ok = 1'b1;
        end
      end
      pslot_pkg::CMD_DISCONNECT: begin
        slot = find_device(id);
        if (slot >= 0) begin
          devices[slot].used = 1'b0;
          ans.ok = 1'b1;
        end
      end
      pslot_pkg::CMD_INPUT: begin
        slot = find_device(id);
        if (slot >= 0 && devices[slot].player[pslot_pkg::PLAYER_W-1]) begin
          if (neutral) devices[slot].armed = 1'b1;
          if (devices[slot].armed && pressed) begin
            p = lowest_free_player();
            if (!p[pslot_pkg::PLAYER_W-1]) begin
              devices[slot].player = p;
              devices[slot].armed  = 1'b0;
              ans.ok = 1'b1;
            end
          end
        end
      end
      pslot_pkg::CMD_REASSIGN: begin
        zero_reserved = 1'b0;
        reassigned    = 1'b1;
        for (int i = 0; i < NUM_DEV; i++) begin
          devices[i].player = pslot_pkg::NO_PLAYER;
          devices[i].armed  = 1'b0;
        end
        ans.ok = 1'b1;
      end
      pslot_pkg::CMD_QUERY: begin
        ans.ok = 1'b1;
      end
      default: begin
      end
    endcase
    slot       = find_device(id);
    ans.player = (slot >= 0) ? devices[slot].player : pslot_pkg::NO_PLAYER;
    ans.held   = held_players();
    return ans;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dev_id_t fresh_id();
    dev_id_t cand;
    bit      clash;
    do begin
      cand  = dev_id_t'($urandom_range(1, (1 << pslot_pkg::DEV_ID_W) - 1));
      clash = 1'b0;
      foreach (id_pool[j]) begin
        if (id_pool[j] == cand) clash = 1'b1;
      end
    end while (clash);
    return cand;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // offer one item, wait for accept, then maybe idle
  task automatic send_item(cmd_t cmd, dev_id_t id,
                           bit built_in, bit neutral, bit pressed);
    int unsigned gap;
    cmd_bus.valid          <= 1'b1;
    cmd_bus.command        <= cmd;
    cmd_bus.device_id      <= id;
    cmd_bus.built_in       <= built_in;
    cmd_bus.neutral        <= neutral;
    cmd_bus.button_pressed <= pressed;
    do @(posedge clk); while (!cmd_bus.ready);
    owed_answers.insert(owed_answers.size(),
                        apply_command(cmd, id, built_in, neutral, pressed));
    gap = pick_gap(cmd_calm);
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_answered();
    if (cmd_bus.valid) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    while (owed_answers.size() != 0) @(posedge clk);
  endtask

  // empty id, built-in reservation, duplicate id
  task automatic test_connect_rules();
    send_item(pslot_pkg::CMD_CONNECT, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'h0001, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_CONNECT, 16'h8000, 1'b1, 1'b0, 1'b0);
  endtask

  // arm on neutral, join on press, already holding, unknown device
  task automatic test_join_flow();
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b0, 1'b1);
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b1, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b0, 1'b1);
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_INPUT, 16'h8000, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_INPUT, 16'h1234, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_DISCONNECT, 16'h1234, 1'b0, 1'b0, 1'b0);
  endtask

  // full table, no free player, ready flag kept until a number frees up
  task automatic test_table_full();
    send_item(pslot_pkg::CMD_CONNECT, 16'h5555, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'hAAAA, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'h0F0F, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'hF0F0, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'h00FF, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'h7E7E, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h5555, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_INPUT, 16'hAAAA, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_DISCONNECT, 16'h5555, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'hAAAA, 1'b0, 1'b0, 1'b1);
  endtask

  // reassign clears numbers and reservation, built-in then joins normally
  task automatic test_reassign();
    send_item(pslot_pkg::CMD_REASSIGN, 16'h0001, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_DISCONNECT, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_CONNECT, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_QUERY, 16'h0001, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_undefined_codes();
    send_item(cmd_t'(pslot_pkg::CMD_QUERY + 1), 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_item(CMD_TOP, 16'hFFFF, 1'b0, 1'b1, 1'b1);
  endtask

  // output held off while items keep coming, then sender waits it out
  task automatic test_backpressure();
    cmd_calm     = 1'b1;
    rsp_hold_req = LONG_HOLD;
    send_item(pslot_pkg::CMD_QUERY, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b1, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h0001, 1'b0, 1'b0, 1'b1);
    send_item(pslot_pkg::CMD_QUERY, 16'h8000, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h8000, 1'b0, 1'b1, 1'b1);
    send_item(pslot_pkg::CMD_QUERY, 16'h0001, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_QUERY, 16'hAAAA, 1'b0, 1'b0, 1'b0);
    send_item(pslot_pkg::CMD_INPUT, 16'h0F0F, 1'b0, 1'b1, 1'b1);
    wait_all_answered();
    cmd_calm = 1'b0;
  endtask

  // random traffic over a small pool of ids so the table fills and empties
  task automatic test_random_traffic();
    int unsigned r;
    int unsigned k;
    int unsigned n;
    cmd_t        cmd;
    dev_id_t     id;
    foreach (id_pool[j]) id_pool[j] = '0;
    n = 0;
    foreach (devices[i]) begin
      if (devices[i].used && n < POOL_SIZE) begin
        id_pool[n] = devices[i].id;
        n++;
      end
    end
    for (k = n; k < POOL_SIZE; k++) id_pool[k] = fresh_id();
    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      cmd_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      // swap in a new id now and then, only one not in the table
      k = $urandom_range(0, POOL_SIZE - 1);
      if (find_device(id_pool[k]) < 0) id_pool[k] = fresh_id();
      repeat (BLOCK_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 22) cmd = pslot_pkg::CMD_CONNECT;
        else if (r < 34) cmd = pslot_pkg::CMD_DISCONNECT;
        else if (r < 80) cmd = pslot_pkg::CMD_INPUT;
        else if (r < 83) cmd = pslot_pkg::CMD_REASSIGN;
        else if (r < 95) cmd = pslot_pkg::CMD_QUERY;
        else cmd = cmd_t'($urandom_range(pslot_pkg::CMD_QUERY + 1, CMD_TOP));
        id = ($urandom_range(0, 39) == 0) ? '0 : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_item(cmd, id, $urandom_range(0, 7) == 0, $urandom_range(0, 1) == 1,
                  $urandom_range(0, 2) != 0);
      end
    end
    cmd_calm = 1'b0;
    rsp_calm = 1'b0;
  endtask

  // result ready with random stalls and requested long holds
  initial begin
    int unsigned pause;
    pause = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_req != 0) begin
        pause        = rsp_hold_req;
        rsp_hold_req = 0;
      end
      if (pause != 0) begin
        rsp_bus.ready <= 1'b0;
        pause--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) pause = pick_gap(rsp_calm);
      end
    end
  end

  // compare each accepted result with the oldest owed answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (owed_answers.size() == 0) begin
        report_mismatch("result with none owed",
                        32'({rsp_bus.ok, rsp_bus.player_number}), '0);
      end else begin
        want = owed_answers.pop_front();
        if (rsp_bus.ok !== want.ok)
          report_mismatch("ok", 32'(rsp_bus.ok), 32'(want.ok));
        if (rsp_bus.player_number !== want.player)
          report_mismatch("player_number", 32'(rsp_bus.player_number), 32'(want.player));
        if (rsp_bus.held_mask !== want.held)
          report_mismatch("held_mask", 32'(rsp_bus.held_mask), 32'(want.held));
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n                  <= 1'b0;
    cmd_bus.valid          <= 1'b0;
    cmd_bus.command        <= pslot_pkg::CMD_QUERY;
    cmd_bus.device_id      <= '0;
    cmd_bus.built_in       <= 1'b0;
    cmd_bus.neutral        <= 1'b0;
    cmd_bus.button_pressed <= 1'b0;
    mismatches    = 0;
    cmd_calm      = 1'b0;
    rsp_calm      = 1'b0;
    rsp_hold_req  = 0;
    zero_reserved = 1'b0;
    reassigned    = 1'b0;
    foreach (devices[i]) begin
      devices[i].used   = 1'b0;
      devices[i].id     = '0;
      devices[i].player = pslot_pkg::NO_PLAYER;
      devices[i].armed  = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_connect_rules();
    test_join_flow();
    test_table_full();
    test_reassign();
    test_undefined_codes();
    test_backpressure();
    test_random_traffic();

    wait_all_answered();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pslot_pkg.sv
hw/rtl/pslot_if.sv
hw/rtl/pslot_table.sv
hw/rtl/pslot_scan.sv
hw/rtl/player_slot_assigner.sv
tb/player_slot_assigner_tb.sv
